### rtl/ctlc_pkg.sv
// ----------------------------------------------------------------------------
// ctlc_pkg
// shared types and character constants for the token counter
// ----------------------------------------------------------------------------
package ctlc_pkg;

  // lexer mode, encoded as reported on the result channel
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_ESCAPE  = 3'd4,
    MODE_NUMBER  = 3'd5,
    MODE_IDENT   = 3'd6
  } mode_t;

  // outcome of lexing one byte
  typedef struct packed {
    mode_t      mode;
    logic [1:0] add;
  } lex_res_t;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;

endpackage

### rtl/c_like_token_counter.sv
// ----------------------------------------------------------------------------
// c_like_token_counter
// token counter for a c-like source byte stream
// ----------------------------------------------------------------------------
// Takes one source byte per request and returns one result per byte: the
// tokens recognised on that byte, the running saturating count, the lexer
// mode reached and a flag closing the text. Line comments, strings, numbers,
// identifiers and single-byte operators each count once; blanks are skipped.
// A slash is held one byte to tell a comment from an operator, so a byte
// can report two tokens. One byte is accepted every cycle while the result
// is not stalled, a rate set by the loop through the mode and count
// registers. A result passes through the input register and then the
// result register; a stalled result holds the input register, so at most
// two bytes are in flight. After the final byte the mode and count return to
// idle and zero.
module c_like_token_counter #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // source byte requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_last,
  // result requests
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_added,
  output logic [15:0] out_total,
  output logic [2:0]  out_mode,
  output logic        out_done_res
);

  // input register stage
  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_last_r;

  // lexer state
  ctlc_pkg::mode_t mode_r;
  ctlc_pkg::mode_t mode_nxt;

  // result register stage
  logic        out_valid_r;
  logic [1:0]  out_added_r;
  logic [15:0] out_total_r;
  logic [2:0]  out_mode_r;
  logic        out_done_r;

  logic               advance;   // result register free or being taken
  logic               step;      // input register item is processed this cycle
  logic               in_accept;
  ctlc_pkg::lex_res_t lex_res;
  logic [15:0]        total_nxt;

  assign advance   = !out_valid_r || !out_stall;
  assign step      = advance && s1_valid_r;
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  // input register, refilled in the same cycle it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last;
    end
  end

  // byte decode against the current mode
  ctlc_lex u_lex (
    .mode (mode_r),
    .ch   (s1_ch_r),
    .last (s1_last_r),
    .res  (lex_res)
  );

  // saturating count, cleared after the closing byte
  ctlc_accum #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (step),
    .add   (lex_res.add),
    .last  (s1_last_r),
    .total (total_nxt)
  );

  // mode returns to idle once the text is closed
  assign mode_nxt = s1_last_r ? ctlc_pkg::MODE_IDLE : lex_res.mode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ctlc_pkg::MODE_IDLE;
    end else if (step) begin
      mode_r <= mode_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_added_r <= lex_res.add;
      out_total_r <= total_nxt;
      out_mode_r  <= lex_res.mode;
      out_done_r  <= s1_last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_added    = out_added_r;
  assign out_total    = out_total_r;
  assign out_mode     = out_mode_r;
  assign out_done_res = out_done_r;

  // an empty input register never holds off a request
  a_no_idle_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty input register");

  // a byte never reports three tokens
  a_added_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_added != 2'd3))
    else $error("token increment out of range");

  // closing byte leaves the lexer idle
  a_idle_after_last : assert property (@(posedge clk) disable iff (!rst_n)
    (step && s1_last_r) |=> (mode_r == ctlc_pkg::MODE_IDLE))
    else $error("lexer not idle after closing byte");

  // a held slash or escape is only ever reported on a byte that is not the last
  a_slash_not_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> (out_mode != 3'(ctlc_pkg::MODE_ESCAPE)
                                     && out_mode != 3'(ctlc_pkg::MODE_SLASH)))
    else $error("deferred mode on closing byte");

endmodule

### rtl/ctlc_lex.sv
// ----------------------------------------------------------------------------
// ctlc_lex
// next-mode and token-count decode for one source byte
// ----------------------------------------------------------------------------
module ctlc_lex (
  input  ctlc_pkg::mode_t    mode,
  input  logic [7:0]         ch,
  input  logic               last,
  output ctlc_pkg::lex_res_t res
);

  logic is_digit;
  logic is_alpha;
  logic is_blank;
  ctlc_pkg::lex_res_t idle_res;

  assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
  assign is_alpha = ((ch >= 8'h61) && (ch <= 8'h7A)) ||
                    ((ch >= 8'h41) && (ch <= 8'h5A)) || (ch == ctlc_pkg::CH_USCORE);
  assign is_blank = (ch == ctlc_pkg::CH_SPACE) || (ch == ctlc_pkg::CH_TAB) ||
                    (ch == ctlc_pkg::CH_NL);

  // byte taken as the start of a new token
  always_comb begin
    idle_res.add  = 2'd1;
    idle_res.mode = ctlc_pkg::MODE_IDLE;
    priority if (is_blank) begin
      idle_res.add = 2'd0;
    end else if ((ch == ctlc_pkg::CH_SLASH) && !last) begin
      idle_res.add  = 2'd0;
      idle_res.mode = ctlc_pkg::MODE_SLASH;
    end else if (ch == ctlc_pkg::CH_QUOTE) begin
      idle_res.mode = ctlc_pkg::MODE_STRING;
    end else if (is_digit) begin
      idle_res.mode = ctlc_pkg::MODE_NUMBER;
    end else if (is_alpha) begin
      idle_res.mode = ctlc_pkg::MODE_IDENT;
    end else begin
      idle_res.mode = ctlc_pkg::MODE_IDLE;
    end
  end

  always_comb begin
    res = idle_res;
    unique case (mode)
      ctlc_pkg::MODE_SLASH: begin
        if (ch == ctlc_pkg::CH_SLASH) begin
          res.add  = 2'd1;
          res.mode = ctlc_pkg::MODE_COMMENT;
        end else begin
          // pending slash is an operator, then relex from idle
          res.add  = idle_res.add + 2'd1;
          res.mode = idle_res.mode;
        end
      end
      ctlc_pkg::MODE_COMMENT: begin
        res.add  = 2'd0;
        res.mode = (ch == ctlc_pkg::CH_NL) ? ctlc_pkg::MODE_IDLE : ctlc_pkg::MODE_COMMENT;
      end
      ctlc_pkg::MODE_STRING: begin
        res.add = 2'd0;
        priority if (ch == ctlc_pkg::CH_QUOTE) begin
          res.mode = ctlc_pkg::MODE_IDLE;
        end else if ((ch == ctlc_pkg::CH_BSLASH) && !last) begin
          res.mode = ctlc_pkg::MODE_ESCAPE;
        end else begin
          res.mode = ctlc_pkg::MODE_STRING;
        end
      end
      ctlc_pkg::MODE_ESCAPE: begin
        res.add  = 2'd0;
        res.mode = ctlc_pkg::MODE_STRING;
      end
      ctlc_pkg::MODE_NUMBER: begin
        if (is_digit || (ch == ctlc_pkg::CH_DOT)) begin
          res.add  = 2'd0;
          res.mode = ctlc_pkg::MODE_NUMBER;
        end
      end
      ctlc_pkg::MODE_IDENT: begin
        if (is_alpha || is_digit) begin
          res.add  = 2'd0;
          res.mode = ctlc_pkg::MODE_IDENT;
        end
      end
      default: begin
        res = idle_res;
      end
    endcase
  end

endmodule

### rtl/ctlc_accum.sv
// ----------------------------------------------------------------------------
// ctlc_accum
// saturating token count register, cleared after the final byte
// ----------------------------------------------------------------------------
module ctlc_accum #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [1:0]  add,
  input  logic        last,
  output logic [15:0] total
);

  localparam int TW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH:0] CMAX = {1'b0, {COUNT_WIDTH{1'b1}}};

  logic [COUNT_WIDTH-1:0] count_r;
  logic [COUNT_WIDTH-1:0] count_nxt;
  logic [COUNT_WIDTH:0]   sum;
  logic [TW-1:0]          count_ext;

  assign sum       = {1'b0, count_r} + (COUNT_WIDTH + 1)'(add);
  assign count_nxt = (sum > CMAX) ? CMAX[COUNT_WIDTH-1:0] : sum[COUNT_WIDTH-1:0];
  assign count_ext = TW'(count_nxt);
  assign total     = count_ext[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (en) begin
      count_r <= last ? '0 : count_nxt;
    end
  end

endmodule

### tb/tb_c_like_token_counter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_c_like_token_counter
// self-checking bench for the c-like source token counter
// ----------------------------------------------------------------------------
// Source bytes are sent through the valid/stall request channel and every
// accepted byte is run through a behavioural lexer kept in the bench. Each
// result request is checked field by field against the oldest prediction.
// A short table of hand-picked bytes comes first, then random texts built
// from identifiers, numbers, strings, comments, operators, blanks and noise.
// Both sides idle in random bursts; the receiver also holds off once for
// a long stretch so that the block backs up onto its input.
// ----------------------------------------------------------------------------
module tb_c_like_token_counter;

  localparam int          CNT_W      = 16;
  localparam int unsigned CNT_MAX    = (32'd1 << CNT_W) - 1;
  localparam int          RAND_ITEMS = 1150;
  localparam int          HOLD_LEN   = 200;

  // one result request as seen on the output
  typedef struct {
    logic [1:0]      added;
    logic [15:0]     total;
    ctlc_pkg::mode_t mode;
    logic            done;
  } tok_res_t;

  // one row of the directed table; chk marks a result typed in by hand
  typedef struct {
    logic [7:0]      ch;
    logic            last;
    logic            chk;
    logic [1:0]      added;
    logic [15:0]     total;
    ctlc_pkg::mode_t mode;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_ch;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_added;
  logic [15:0] out_total;
  logic [2:0]  out_mode;
  logic        out_done_res;

  // bench copy of the lexer state
  ctlc_pkg::mode_t lex_state = ctlc_pkg::MODE_IDLE;
  logic [31:0]     tok_count = '0;

  tok_res_t    expected_q [$];
  logic [7:0]  text_q [$];
  int          errors     = 0;
  int          rand_items = 0;
  bit          jitter_on  = 1'b1;  // random idling allowed
  bit          calm       = 1'b0;  // no idling at all
  bit          hold_req   = 1'b0;  // asks the receiver for one long hold-off

  // directed bytes, walked from reset; totals only where obvious
  dir_row_t dir_rows [26] = '{
    '{8'h61, 1'b0, 1'b1, 2'd1, 16'd1, ctlc_pkg::MODE_IDENT},    // identifier opens
    '{8'h5A, 1'b0, 1'b0, 2'd0, 16'd0, ctlc_pkg::MODE_IDLE},
    '{ctlc_pkg::CH_SPACE, 1'b0, 1'b0, 2'd0, 16'd0, ctlc_pkg::MODE_IDLE},
    '{ctlc_pkg::CH_SLASH, 1'b0, 1'b1, 2'd0, 16'd1, ctlc_pkg::MODE_SLASH},  // slash held
    '{ctlc_pkg::CH_SLASH, 1'b0, 1'b1, 2'd1, 16'd2, ctlc_pkg::MODE_COMMENT},
    '{8'h78, 1'b0, 1'b0, 2'd0, 16'd0, ctlc_pkg::MODE_IDLE},
    '{ctlc_pkg::CH_NL, 1'b0, 1'b0, 2'd0, 16'd0, ctlc_pkg::MODE_IDLE},
    '{ctlc_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, 16'd0, ctlc_pkg::MODE_IDLE},
    '{8'h39, 1'b0, 1'b1, 2'd2, 16'd4, ctlc_pkg::MODE_NUMBER},   // slash then digit
    '{ctlc_pkg::CH_DOT, 1'b0, 1'b0, 2'd0, 16'd0, ctlc_pkg::MODE_IDLE},
    '{ctlc_pkg::CH_USCORE, 1'b0, 1'b0, 2'd0, 16'd0, ctlc_pkg::MODE_IDLE},
    '{ctlc_pkg::CH_QUOTE, 1'b0, 1'b0, 2'd0, 16'd0, ctlc_pkg::MODE_IDLE},
    '{ctlc_pkg::CH_BSLASH, 1'b0, 1'b0, 2'd0, 16'd0, ctlc_pkg::MODE_IDLE},
    '{ctlc_pkg::CH_QUOTE, 1'b0, 1'b0, 2'd0, 16'd0, ctlc_pkg::MODE_IDLE},  // escaped
    '{ctlc_pkg::CH_QUOTE, 1'b0, 1'b0, 2'd0, 16'd0, ctlc_pkg::MODE_IDLE},
    '{ctlc_pkg::CH_TAB, 1'b0, 1'b0, 2'd0, 16'd0, ctlc_pkg::MODE_IDLE},
    '{8'hFF, 1'b0, 1'b1, 2'd1, 16'd7, ctlc_pkg::MODE_IDLE},     // top byte value
    '{8'h01, 1'b0, 1'b1, 2'd1, 16'd8, ctlc_pkg::MODE_IDLE},     // lowest byte value sent
    '{ctlc_pkg::CH_SLASH, 1'b1, 1'b1, 2'd1, 16'd9, ctlc_pkg::MODE_IDLE},  // closes
    '{ctlc_pkg::CH_QUOTE, 1'b0, 1'b1, 2'd1, 16'd1, ctlc_pkg::MODE_STRING},
    '{ctlc_pkg::CH_BSLASH, 1'b1, 1'b1, 2'd0, 16'd1, ctlc_pkg::MODE_STRING},
    '{8'h71, 1'b1, 1'b1, 2'd1, 16'd1, ctlc_pkg::MODE_IDENT},    // one-byte text
    '{ctlc_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, 16'd0, ctlc_pkg::MODE_IDLE},
    '{ctlc_pkg::CH_SLASH, 1'b1, 1'b1, 2'd1, 16'd1, ctlc_pkg::MODE_COMMENT},
    '{8'h37, 1'b0, 1'b0, 2'd0, 16'd0, ctlc_pkg::MODE_IDLE},
    '{8'h78, 1'b1, 1'b0, 2'd0, 16'd0, ctlc_pkg::MODE_IDLE}
  };

  c_like_token_counter #(
    .COUNT_WIDTH (CNT_W)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_ch        (in_ch),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_added    (out_added),
    .out_total    (out_total),
    .out_mode     (out_mode),
    .out_done_res (out_done_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall limit, far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // character classes and the behavioural lexer
  // --------------------------------------------------------------------------
  function automatic bit is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           c == ctlc_pkg::CH_USCORE;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == ctlc_pkg::CH_SPACE || c == ctlc_pkg::CH_TAB || c == ctlc_pkg::CH_NL;
  endfunction

  // a byte seen as the first of a fresh token
  function automatic ctlc_pkg::lex_res_t open_token(input logic [7:0] c, input logic l);
    ctlc_pkg::lex_res_t r;
    r.add = 2'd1;
    if (is_blank(c)) begin
      r.add  = 2'd0;
      r.mode = ctlc_pkg::MODE_IDLE;
    end else if (c == ctlc_pkg::CH_SLASH && !l) begin
      // wait one byte: comment or operator
      r.add  = 2'd0;
      r.mode = ctlc_pkg::MODE_SLASH;
    end else if (c == ctlc_pkg::CH_QUOTE) begin
      r.mode = ctlc_pkg::MODE_STRING;
    end else if (is_digit(c)) begin
      r.mode = ctlc_pkg::MODE_NUMBER;
    end else if (is_alpha(c)) begin
      r.mode = ctlc_pkg::MODE_IDENT;
    end else begin
      r.mode = ctlc_pkg::MODE_IDLE;
    end
    return r;
  endfunction

  // advances the bench lexer by one byte and returns the result it implies
  function automatic tok_res_t lex_step(input logic [7:0] c, input logic l);
    tok_res_t r;
    ctlc_pkg::lex_res_t o;
    logic [1:0] n;
    ctlc_pkg::mode_t nxt;
    n   = 2'd0;
    nxt = ctlc_pkg::MODE_IDLE;
    case (lex_state)
      ctlc_pkg::MODE_SLASH: begin
        // the pending slash is a token either way
        if (c == ctlc_pkg::CH_SLASH) begin
          nxt = ctlc_pkg::MODE_COMMENT;
        end else begin
          o   = open_token(c, l);
          n   = o.add;
          nxt = o.mode;
        end
        n = n + 2'd1;
      end
      ctlc_pkg::MODE_COMMENT:
        nxt = (c == ctlc_pkg::CH_NL) ? ctlc_pkg::MODE_IDLE : ctlc_pkg::MODE_COMMENT;
      ctlc_pkg::MODE_STRING: begin
        if (c == ctlc_pkg::CH_QUOTE) nxt = ctlc_pkg::MODE_IDLE;
        else if (c == ctlc_pkg::CH_BSLASH && !l) nxt = ctlc_pkg::MODE_ESCAPE;
        else nxt = ctlc_pkg::MODE_STRING;
      end
      ctlc_pkg::MODE_ESCAPE: nxt = ctlc_pkg::MODE_STRING;
      ctlc_pkg::MODE_NUMBER: begin
        if (is_digit(c) || c == ctlc_pkg::CH_DOT) begin
          nxt = ctlc_pkg::MODE_NUMBER;
        end else begin
          o   = open_token(c, l);
          n   = o.add;
          nxt = o.mode;
        end
      end
      ctlc_pkg::MODE_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          nxt = ctlc_pkg::MODE_IDENT;
        end else begin
          o   = open_token(c, l);
          n   = o.add;
          nxt = o.mode;
        end
      end
      default: begin
        o   = open_token(c, l);
        n   = o.add;
        nxt = o.mode;
      end
    endcase
    // count saturates but added still shows what was recognised
    repeat (n) if (tok_count < CNT_MAX) tok_count++;
    r.added = n;
    r.total = tok_count[15:0];
    r.mode  = nxt;
    r.done  = l;
    lex_state = l ? ctlc_pkg::MODE_IDLE : nxt;
    if (l) tok_count = '0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // random text pieces
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rand_any();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] rand_alpha();
    int k;
    k = $urandom_range(0, 52);
    if (k < 26) return 8'h61 + 8'(k);
    if (k < 52) return 8'h41 + 8'(k - 26);
    return ctlc_pkg::CH_USCORE;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_alpha();
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 2))
      0:       return ctlc_pkg::CH_SPACE;
      1:       return ctlc_pkg::CH_TAB;
      default: return ctlc_pkg::CH_NL;
    endcase
  endfunction

  // a one-byte operator: anything that opens no other kind of token
  function automatic logic [7:0] rand_op();
    logic [7:0] c;
    do c = rand_any();
    while (is_alpha(c) || is_digit(c) || is_blank(c) || c == ctlc_pkg::CH_QUOTE ||
           c == ctlc_pkg::CH_SLASH);
    return c;
  endfunction

  // appends one token, mostly well formed, sometimes broken or plain noise
  task automatic add_token();
    int n;
    int i;
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1: begin
        text_q.push_back(rand_alpha());
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++) text_q.push_back(rand_alnum());
      end
      2: begin
        text_q.push_back(rand_digit());
        n = $urandom_range(0, 5);
        for (i = 0; i < n; i++)
          text_q.push_back(($urandom_range(0, 3) == 0) ? ctlc_pkg::CH_DOT : rand_digit());
      end
      3: begin
        text_q.push_back(ctlc_pkg::CH_QUOTE);
        n = $urandom_range(0, 8);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 5) == 0) begin
            // escape, the next byte may well be a quote
            text_q.push_back(ctlc_pkg::CH_BSLASH);
            text_q.push_back(rand_any());
          end else begin
            c = rand_any();
            text_q.push_back((c == ctlc_pkg::CH_QUOTE) ? 8'h41 : c);
          end
        end
        if ($urandom_range(0, 9) != 0) text_q.push_back(ctlc_pkg::CH_QUOTE);
      end
      4: begin
        text_q.push_back(ctlc_pkg::CH_SLASH);
        text_q.push_back(ctlc_pkg::CH_SLASH);
        n = $urandom_range(0, 10);
        for (i = 0; i < n; i++) begin
          c = rand_any();
          text_q.push_back((c == ctlc_pkg::CH_NL) ? ctlc_pkg::CH_SPACE : c);
        end
        if ($urandom_range(0, 6) != 0) text_q.push_back(ctlc_pkg::CH_NL);
      end
      5, 6: text_q.push_back(rand_op());
      7: begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) text_q.push_back(rand_blank());
      end
      8: text_q.push_back(rand_any());
      default: begin
        // lone slash followed by whatever comes
        text_q.push_back(ctlc_pkg::CH_SLASH);
        text_q.push_back(rand_any());
      end
    endcase
    if ($urandom_range(0, 1) == 0) text_q.push_back(rand_blank());
  endtask

  // --------------------------------------------------------------------------
  // request driver
  // --------------------------------------------------------------------------
  // offers one byte, waits for its request to be taken, records the result
  task automatic push_byte(input logic [7:0] c, input logic l, input logic chk,
                           input tok_res_t typed);
    tok_res_t guess;
    in_valid <= 1'b1;
    in_ch    <= c;
    in_last  <= l;
    do @(posedge clk); while (in_stall !== 1'b0);
    guess = lex_step(c, l);
    if (chk) expected_q.push_back(typed);
    else expected_q.push_back(guess);
    // within this task valid only drops here, never in the step that raises it again
    if (jitter_on && !calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] c, input logic l);
    tok_res_t none;
    none = '{added: 2'd0, total: 16'd0, mode: ctlc_pkg::MODE_IDLE, done: 1'b0};
    push_byte(c, l, 1'b0, none);
  endtask

  // --------------------------------------------------------------------------
  // result receiver: random stall bursts and the one long hold-off
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_cnt;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (hold_cnt = 0; hold_cnt < HOLD_LEN; hold_cnt++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (jitter_on && !calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  function automatic void cmp_field(input string name, input logic [15:0] want_v,
                                    input logic [15:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    tok_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        $error("result with nothing expected: total %0d mode %0d", out_total, out_mode);
      end else begin
        want = expected_q.pop_front();
        cmp_field("added", 16'(want.added), 16'(out_added));
        cmp_field("total", want.total, out_total);
        cmp_field("mode", 16'(want.mode), 16'(out_mode));
        cmp_field("done_res", 16'(want.done), 16'(out_done_res));
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int k;
    int ntok;
    bit held;
    bit drained;
    tok_res_t typed;
    held    = 1'b0;
    drained = 1'b0;
    in_valid <= 1'b0;
    in_ch    <= 8'h00;
    in_last  <= 1'b0;
    rst_n    <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (k = 0; k < $size(dir_rows); k++) begin
      typed.added = dir_rows[k].added;
      typed.total = dir_rows[k].total;
      typed.mode  = dir_rows[k].mode;
      typed.done  = dir_rows[k].last;
      push_byte(dir_rows[k].ch, dir_rows[k].last, dir_rows[k].chk, typed);
    end

    // random texts
    while (rand_items < RAND_ITEMS) begin
      jitter_on = ($urandom_range(0, 3) != 0);
      if (!held && rand_items >= 300) begin
        // receiver holds off while requests keep coming
        held      = 1'b1;
        jitter_on = 1'b0;
        hold_req  = 1'b1;
      end
      if (!drained && rand_items >= 650) begin
        // sender pauses until every result is back
        drained = 1'b1;
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
      end
      if (rand_items >= RAND_ITEMS - 150) calm = 1'b1;
      text_q.delete();
      ntok = $urandom_range(1, 10);
      repeat (ntok) add_token();
      for (k = 0; k < text_q.size(); k++) begin
        send_byte(text_q[k], k == text_q.size() - 1);
        rand_items++;
      end
    end

    // drain, then keep watching for anything unexpected before the verdict
    in_valid <= 1'b0;
    k = 0;
    while (expected_q.size() != 0 && k < 2000) begin
      @(posedge clk);
      k++;
    end
    repeat (8) @(posedge clk);
    if (expected_q.size() != 0) begin
      errors += int'(expected_q.size());
      $error("%0d results never arrived", expected_q.size());
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
